// ===== rtl/core/yuvmb_pkg.sv =====
package yuvmb_pkg;

   localparam int BLOCK_DIM_DEFAULT = 16;

   localparam int COORD_W  = 11;
   localparam int WORD_W   = 32;
   localparam int OFFSET_W = 20;
   localparam int PIXEL_W  = 16;
   localparam int CHAN_W   = 5;

   // signed accumulator for one color channel, Q.16
   localparam int ACC_W = 28;

   localparam int COEF_RV     = 89831;
   localparam int COEF_GV     = 45744;
   localparam int COEF_GU     = 22127;
   localparam int COEF_BU     = 113538;
   localparam int CHROMA_BIAS = 128;

   // floor divide by 8 * 65536
   localparam int CHAN_SHIFT = 19;

   localparam logic ALPHA_OPAQUE = 1'b1;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [COORD_W-1:0] FRAME_WIDTH_RESET  = 11'd320;
   localparam logic [COORD_W-1:0] FRAME_HEIGHT_RESET = 11'd240;

   typedef enum logic {
      CSR_FRAME_WIDTH  = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [WORD_W-1:0]  packed_word;
      logic [COORD_W-1:0] block_left;
      logic [COORD_W-1:0] block_top;
      logic [COORD_W-1:0] block_right;
      logic [COORD_W-1:0] block_bottom;
   } req_type;

   typedef struct packed {
      logic [OFFSET_W-1:0] pixel_offset;
      logic [PIXEL_W-1:0]  first_pixel;
      logic [PIXEL_W-1:0]  second_pixel;
   } rsp_type;

   typedef struct packed {
      logic [COORD_W-1:0] frame_width;
      logic [COORD_W-1:0] frame_height;
   } cfg_type;

   // negative gives zero, above 31 saturates
   function automatic logic [CHAN_W-1:0] chan5(input logic signed [ACC_W-1:0] acc);
      logic [CHAN_W-1:0] res;
      if (acc[ACC_W-1]) begin
         res = '0;
      end else if (|acc[ACC_W-2:CHAN_SHIFT+CHAN_W]) begin
         res = '1;
      end else begin
         res = acc[CHAN_SHIFT+CHAN_W-1:CHAN_SHIFT];
      end
      return res;
   endfunction

endpackage

// ===== rtl/core/yuvmb_csr.sv =====
module yuvmb_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [yuvmb_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [yuvmb_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [yuvmb_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                                pready,
   output yuvmb_pkg::cfg_type                  cfg
);

   logic [yuvmb_pkg::COORD_W-1:0] frame_width_ff, frame_width_in;
   logic [yuvmb_pkg::COORD_W-1:0] frame_height_ff, frame_height_in;
   yuvmb_pkg::csr_index_type      index;
   logic                          wr_en;

   // low address bits ignored, one register per word
   assign index  = yuvmb_pkg::csr_index_type'(paddr[2]);
   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite && pready;

   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      if (wr_en) begin
         unique case (index)
            yuvmb_pkg::CSR_FRAME_WIDTH: begin
               frame_width_in = pwdata[yuvmb_pkg::COORD_W-1:0];
            end
            yuvmb_pkg::CSR_FRAME_HEIGHT: begin
               frame_height_in = pwdata[yuvmb_pkg::COORD_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (index)
         yuvmb_pkg::CSR_FRAME_WIDTH: begin
            prdata = yuvmb_pkg::CSR_DATA_W'(frame_width_ff);
         end
         yuvmb_pkg::CSR_FRAME_HEIGHT: begin
            prdata = yuvmb_pkg::CSR_DATA_W'(frame_height_ff);
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= yuvmb_pkg::FRAME_WIDTH_RESET;
         frame_height_ff <= yuvmb_pkg::FRAME_HEIGHT_RESET;
      end else begin
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
      end
   end

   assign cfg.frame_width  = frame_width_ff;
   assign cfg.frame_height = frame_height_ff;

endmodule

// ===== rtl/core/yuvmb_pos.sv =====
module yuvmb_pos #(
   parameter int BLOCK_DIM = yuvmb_pkg::BLOCK_DIM_DEFAULT,
   parameter int HALF_DIM  = BLOCK_DIM / 2,
   parameter int ROW_W     = $clog2(BLOCK_DIM),
   parameter int COL_W     = $clog2(HALF_DIM)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   output logic [ROW_W-1:0] row,
   output logic [COL_W-1:0] col
);

   logic [ROW_W-1:0] row_ff, row_in;
   logic [COL_W-1:0] col_ff, col_in;

   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      if (advance) begin
         if (col_ff == COL_W'(HALF_DIM - 1)) begin
            col_in = '0;
            // wrap to the first word of the next block
            if (row_ff == ROW_W'(BLOCK_DIM - 1)) begin
               row_in = '0;
            end else begin
               row_in = row_ff + ROW_W'(1);
            end
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
      end else begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

   assign row = row_ff;
   assign col = col_ff;

endmodule

// ===== rtl/core/yuvmb_pixel.sv =====
module yuvmb_pixel (
   input  logic [7:0]                        luma,
   input  logic [7:0]                        cb,
   input  logic [7:0]                        cr,
   output logic [yuvmb_pkg::PIXEL_W-1:0]     pixel
);

   localparam int AW = yuvmb_pkg::ACC_W;

   logic signed [AW-1:0] yy;
   logic signed [AW-1:0] du;
   logic signed [AW-1:0] dv;
   logic signed [AW-1:0] acc_r;
   logic signed [AW-1:0] acc_g;
   logic signed [AW-1:0] acc_b;

   always_comb begin
      yy = $signed(AW'({luma, 16'h0000}));
      du = $signed(AW'(cb)) - $signed(AW'(yuvmb_pkg::CHROMA_BIAS));
      dv = $signed(AW'(cr)) - $signed(AW'(yuvmb_pkg::CHROMA_BIAS));
      acc_r = yy + $signed(AW'(yuvmb_pkg::COEF_RV)) * dv;
      acc_g = yy - $signed(AW'(yuvmb_pkg::COEF_GV)) * dv
                 - $signed(AW'(yuvmb_pkg::COEF_GU)) * du;
      acc_b = yy + $signed(AW'(yuvmb_pkg::COEF_BU)) * du;
      pixel = {yuvmb_pkg::chan5(acc_r), yuvmb_pkg::chan5(acc_g),
               yuvmb_pkg::chan5(acc_b), yuvmb_pkg::ALPHA_OPAQUE};
   end

endmodule

// ===== rtl/core/yuv_macroblock_to_rgb5551.sv =====
// channel   direction  handshake          payload
// req       in         req_valid/ready    yuvmb_pkg::req_type, one packed word
// rsp       out        rsp_valid/ready    yuvmb_pkg::rsp_type, offset and two pixels
// csr       in         psel/penable       frame_width at 0x0, frame_height at 0x4
//
// one word per cycle sustained unless the rsp side stalls
// stages: input register, then clip, offset multiply and color convert into the
// result register; words outside the clip are dropped there
// a stalled result holds the result register; an empty input stage takes one more
// word and then holds too; it still takes a word when the result register drains
// synchronous reset clears the word counter and both valid bits, not the data registers
module yuv_macroblock_to_rgb5551 #(
   parameter int BLOCK_DIM = yuvmb_pkg::BLOCK_DIM_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  yuvmb_pkg::req_type                req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output yuvmb_pkg::rsp_type                rsp_data,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [yuvmb_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [yuvmb_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [yuvmb_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                              pready
);

   localparam int HALF_DIM = BLOCK_DIM / 2;
   localparam int ROW_W    = $clog2(BLOCK_DIM);
   localparam int COL_W    = $clog2(HALF_DIM);
   localparam int CW       = yuvmb_pkg::COORD_W;
   localparam int PROD_W   = 2 * CW + 1;

   yuvmb_pkg::cfg_type cfg;
   logic [ROW_W-1:0]   pos_row;
   logic [COL_W-1:0]   pos_col;

   logic               req_fire;
   logic               down_ready;
   logic               s0_ready;

   logic               s0_valid_ff, s0_valid_in;
   yuvmb_pkg::req_type s0_data_ff, s0_data_in;
   logic [ROW_W-1:0]   s0_row_ff, s0_row_in;
   logic [COL_W-1:0]   s0_col_ff, s0_col_in;

   logic               rsp_valid_ff, rsp_valid_in;
   yuvmb_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic [CW-1:0]      draw_w;
   logic [CW-1:0]      draw_h;
   logic [CW:0]        col_px;
   logic               visible;
   logic [CW:0]        row_abs;
   logic [PROD_W-1:0]  offset_sum;
   logic [yuvmb_pkg::PIXEL_W-1:0] pix0;
   logic [yuvmb_pkg::PIXEL_W-1:0] pix1;

   yuvmb_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   yuvmb_pos #(
      .BLOCK_DIM (BLOCK_DIM),
      .HALF_DIM  (HALF_DIM),
      .ROW_W     (ROW_W),
      .COL_W     (COL_W)
   ) u_pos (
      .clock   (clock),
      .reset   (reset),
      .advance (req_fire),
      .row     (pos_row),
      .col     (pos_col)
   );

   assign down_ready = !rsp_valid_ff || rsp_ready;
   assign s0_ready   = !s0_valid_ff || down_ready;
   assign req_ready  = s0_ready;
   assign req_fire   = req_valid && req_ready;

   always_comb begin
      s0_valid_in = s0_valid_ff;
      s0_data_in  = s0_data_ff;
      s0_row_in   = s0_row_ff;
      s0_col_in   = s0_col_ff;
      if (s0_ready) begin
         s0_valid_in = req_valid;
         s0_data_in  = req_data;
         s0_row_in   = pos_row;
         s0_col_in   = pos_col;
      end
   end

   // clip against the frame
   always_comb begin
      col_px = (CW + 1)'({s0_col_ff, 1'b0});
      if (s0_data_ff.block_right > cfg.frame_width) begin
         draw_w = cfg.frame_width - s0_data_ff.block_left;
      end else begin
         draw_w = CW'(BLOCK_DIM);
      end
      if (s0_data_ff.block_bottom > cfg.frame_height) begin
         draw_h = cfg.frame_height - s0_data_ff.block_top;
      end else begin
         draw_h = CW'(BLOCK_DIM);
      end
      visible = (s0_data_ff.block_left < cfg.frame_width)
             && (s0_data_ff.block_top < cfg.frame_height)
             && ((CW + 1)'(s0_row_ff) < (CW + 1)'(draw_h))
             && (col_px < (CW + 1)'(draw_w));
   end

   always_comb begin
      row_abs    = (CW + 1)'(s0_data_ff.block_top) + (CW + 1)'(s0_row_ff);
      offset_sum = PROD_W'(row_abs) * PROD_W'(cfg.frame_width)
                 + PROD_W'(s0_data_ff.block_left) + PROD_W'(col_px);
   end

   yuvmb_pixel u_pix0 (
      .luma  (s0_data_ff.packed_word[7:0]),
      .cb    (s0_data_ff.packed_word[31:24]),
      .cr    (s0_data_ff.packed_word[15:8]),
      .pixel (pix0)
   );

   yuvmb_pixel u_pix1 (
      .luma  (s0_data_ff.packed_word[23:16]),
      .cb    (s0_data_ff.packed_word[31:24]),
      .cr    (s0_data_ff.packed_word[15:8]),
      .pixel (pix1)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (down_ready) begin
         rsp_valid_in              = s0_valid_ff && visible;
         rsp_data_in.pixel_offset  = offset_sum[yuvmb_pkg::OFFSET_W-1:0];
         rsp_data_in.first_pixel   = pix0;
         rsp_data_in.second_pixel  = pix1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff  <= s0_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s0_data_ff  <= s0_data_in;
      s0_row_ff   <= s0_row_in;
      s0_col_ff   <= s0_col_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== rtl/core/yuvmb_checker.sv =====
module yuvmb_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input yuvmb_pkg::rsp_type rsp_data
);

   // a result held back keeps its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // a new result comes from an item taken earlier, by way of the input register
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("result without a matching item");

   // a stalled result with the input stage full blocks new items
   a_no_take_when_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready && $past(rsp_valid && !rsp_ready)
         && $past(req_valid && req_ready) |-> !req_ready)
      else $error("item taken with both stages full");

endmodule

bind yuv_macroblock_to_rgb5551 yuvmb_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// ===== sim/yuv_macroblock_to_rgb5551_pixel_check.sv =====
`timescale 1ns / 1ps

module yuv_macroblock_to_rgb5551_pixel_check #(
   parameter int BLOCK_DIM = yuvmb_pkg::BLOCK_DIM_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_ready,
   input  yuvmb_pkg::req_type                req_data,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  yuvmb_pkg::rsp_type                rsp_data,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [yuvmb_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [yuvmb_pkg::CSR_DATA_W-1:0]  pwdata,
   input  logic                              pready,
   output int                                mismatch_count,
   output int                                pending_pixels
);
   import yuvmb_pkg::*;

   localparam int HALF_DIM        = BLOCK_DIM / 2;
   localparam int WORDS_PER_BLOCK = BLOCK_DIM * HALF_DIM;

   logic [COORD_W-1:0] frame_w;
   logic [COORD_W-1:0] frame_h;
   int unsigned        word_idx;
   rsp_type            expected_pixels[$];

   // floor by 2^19, negative to zero, saturate at 31
   function automatic logic [CHAN_W-1:0] clamp5(input longint acc);
      if (acc < 0) begin
         return '0;
      end
      if ((acc >>> CHAN_SHIFT) > 31) begin
         return '1;
      end
      return acc[CHAN_SHIFT+CHAN_W-1:CHAN_SHIFT];
   endfunction

   function automatic logic [PIXEL_W-1:0] rgba5551(input logic [7:0] y, input logic [7:0] u,
                                                   input logic [7:0] v);
      longint luma;
      longint du;
      longint dv;
      luma = longint'(y) * 65536;
      du   = longint'(u) - CHROMA_BIAS;
      dv   = longint'(v) - CHROMA_BIAS;
      return {clamp5(luma + COEF_RV * dv),
              clamp5(luma - COEF_GV * dv - COEF_GU * du),
              clamp5(luma + COEF_BU * du),
              ALPHA_OPAQUE};
   endfunction

   // pixels for the word at the current block position, if it lies inside the clip
   function automatic bit convert_word(input req_type w, output rsp_type px);
      int unsigned       row;
      int unsigned       col;
      int unsigned       draw_w;
      int unsigned       draw_h;
      int unsigned       lft;
      int unsigned       tp;
      longint unsigned   offset;
      px  = '0;
      row = word_idx / HALF_DIM;
      col = (word_idx % HALF_DIM) * 2;
      lft = w.block_left;
      tp  = w.block_top;
      if (lft >= frame_w || tp >= frame_h) begin
         return 0;
      end
      draw_w = (w.block_right > frame_w) ? frame_w - lft : BLOCK_DIM;
      draw_h = (w.block_bottom > frame_h) ? frame_h - tp : BLOCK_DIM;
      if (row >= draw_h || col >= draw_w) begin
         return 0;
      end
      offset = longint'(tp + row) * frame_w + lft + col;
      px.pixel_offset = offset[OFFSET_W-1:0];
      px.first_pixel  = rgba5551(w.packed_word[7:0], w.packed_word[31:24], w.packed_word[15:8]);
      px.second_pixel = rgba5551(w.packed_word[23:16], w.packed_word[31:24],
                                 w.packed_word[15:8]);
      return 1;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      rsp_type got;
      if (reset) begin
         frame_w        = FRAME_WIDTH_RESET;
         frame_h        = FRAME_HEIGHT_RESET;
         word_idx       = 0;
         mismatch_count = 0;
         expected_pixels.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (csr_index_type'(paddr[CSR_ADDR_W-1:2]))
               CSR_FRAME_WIDTH: begin
                  frame_w = pwdata[COORD_W-1:0];
               end
               CSR_FRAME_HEIGHT: begin
                  frame_h = pwdata[COORD_W-1:0];
               end
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_pixels.size() == 0) begin
               $display("%0t: unexpected item, expected none, actual offset %0d pixels %h %h",
                        $time, rsp_data.pixel_offset, rsp_data.first_pixel,
                        rsp_data.second_pixel);
               mismatch_count++;
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_data.pixel_offset !== want.pixel_offset) begin
                  $display("%0t: pixel_offset expected %0d actual %0d", $time,
                           want.pixel_offset, rsp_data.pixel_offset);
                  mismatch_count++;
               end
               if (rsp_data.first_pixel !== want.first_pixel) begin
                  $display("%0t: first_pixel expected %h actual %h", $time,
                           want.first_pixel, rsp_data.first_pixel);
                  mismatch_count++;
               end
               if (rsp_data.second_pixel !== want.second_pixel) begin
                  $display("%0t: second_pixel expected %h actual %h", $time,
                           want.second_pixel, rsp_data.second_pixel);
                  mismatch_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            if (convert_word(req_data, got)) begin
               expected_pixels.push_back(got);
            end
            // counter steps on every word, drawn or not
            word_idx = (word_idx + 1 >= WORDS_PER_BLOCK) ? 0 : word_idx + 1;
         end
      end
      pending_pixels = expected_pixels.size();
   end

endmodule

// ===== sim/yuv_macroblock_to_rgb5551_tb.sv =====
`timescale 1ns / 1ps

module yuv_macroblock_to_rgb5551_tb;
   import yuvmb_pkg::*;

   localparam int WORDS_PER_BLOCK = BLOCK_DIM_DEFAULT * (BLOCK_DIM_DEFAULT / 2);
   localparam int CYCLE_LIMIT     = 300000;

   logic                    clock     = 1'b0;
   logic                    reset     = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   req_type                 req_data  = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   rsp_type                 rsp_data;
   logic                    psel      = 1'b0;
   logic                    penable   = 1'b0;
   logic                    pwrite    = 1'b0;
   logic [CSR_ADDR_W-1:0]   paddr     = '0;
   logic [CSR_DATA_W-1:0]   pwdata    = '0;
   logic [CSR_DATA_W-1:0]   prdata;
   logic                    pready;

   int mismatch_count;
   int pending_pixels;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int cycle_count    = 0;
   int block_pos      = 0;
   int cur_width      = FRAME_WIDTH_RESET;
   int cur_height     = FRAME_HEIGHT_RESET;

   int width_plan[6]  = '{1024, 1, 0, 1024, 1, 0};
   int height_plan[6] = '{1024, 1, 0, 1, 1024, 0};
   int block_plan[6]  = '{2, 1, 3, 1, 1, 3};

   yuv_macroblock_to_rgb5551 dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   yuv_macroblock_to_rgb5551_pixel_check pixel_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .pready         (pready),
      .mismatch_count (mismatch_count),
      .pending_pixels (pending_pixels)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("yuv_macroblock_to_rgb5551_tb: FAIL");
         $finish;
      end
   end

   function automatic req_type to_req(input logic [31:0] word, input int lft, input int tp,
                                      input int rgt, input int btm);
      req_type r;
      r.packed_word  = word;
      r.block_left   = lft[COORD_W-1:0];
      r.block_top    = tp[COORD_W-1:0];
      r.block_right  = rgt[COORD_W-1:0];
      r.block_bottom = btm[COORD_W-1:0];
      return r;
   endfunction

   task automatic send_word(input req_type item);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      block_pos = (block_pos + 1) % WORDS_PER_BLOCK;
   endtask

   // hold off the sender until every pixel pair is out and the pipe has emptied
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_pixels != 0) @(negedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input int field);
      logic [CSR_DATA_W-1:0] value;
      value = $urandom;
      if ($urandom_range(0, 1)) begin
         value = '0;
      end
      value[COORD_W-1:0] = field[COORD_W-1:0];
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // one macroblock worth of words, finishing the current block if mid-way
   task automatic send_block();
      int lft;
      int tp;
      int rgt;
      int btm;
      int kind;
      lft  = $urandom_range(0, cur_width - 1);
      tp   = $urandom_range(0, cur_height - 1);
      kind = $urandom_range(0, 9);
      case (kind)
         4: lft = cur_width - $urandom_range(1, (cur_width < 16) ? cur_width : 16);
         5: tp  = cur_height - $urandom_range(1, (cur_height < 16) ? cur_height : 16);
         6: lft = $urandom_range(cur_width, 2047);
         7: tp  = $urandom_range(cur_height, 2047);
         default: ;
      endcase
      rgt = lft + BLOCK_DIM_DEFAULT;
      btm = tp + BLOCK_DIM_DEFAULT;
      if (kind == 8) begin
         lft = $urandom_range(0, 2047);
         tp  = $urandom_range(0, 2047);
         rgt = $urandom_range(0, 2047);
         btm = $urandom_range(0, 2047);
      end else if (kind == 9) begin
         // right edge at or left of the left edge, bottom edge random
         rgt = $urandom_range(0, lft);
         btm = $urandom_range(0, 2047);
      end
      do begin
         if ($urandom_range(0, 9) == 0) begin
            send_word(to_req($urandom, $urandom_range(0, 2047), $urandom_range(0, 2047),
                             $urandom_range(0, 2047), $urandom_range(0, 2047)));
         end else begin
            send_word(to_req($urandom, lft, tp, rgt, btm));
         end
      end while (block_pos != 0);
   endtask

   initial begin
      int lft;
      int tp;
      send_idle_pct  = 30;
      recv_stall_pct = 82;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // frame at its reset size, 320 x 240
      send_word(to_req(32'h0000_0000, 0, 0, 0, 0));
      send_word(to_req(32'hFFFF_FFFF, 304, 224, 320, 240));
      send_word(to_req(32'h0000_FFFF, 0, 0, 16, 16));
      send_word(to_req(32'hFF00_FF00, 0, 0, 16, 16));
      send_word(to_req(32'h8080_8080, 0, 0, 16, 16));
      send_word(to_req(32'h00FF_00FF, 0, 0, 16, 16));
      // left or top beyond the frame
      send_word(to_req(32'h1234_5678, 320, 0, 336, 16));
      send_word(to_req(32'h8765_4321, 0, 240, 16, 256));
      send_word(to_req(32'hA5A5_5A5A, 2047, 2047, 2047, 2047));
      // right clip leaves four columns
      send_word(to_req(32'h3C80_C480, 316, 10, 400, 26));
      send_word(to_req(32'h3C80_C480, 316, 10, 400, 26));
      // bottom clip, one row then two rows left
      send_word(to_req(32'h70A0_4090, 0, 239, 16, 300));
      send_word(to_req(32'h70A0_4090, 0, 238, 16, 300));
      send_word(to_req(32'h10F0_F010, 100, 50, 0, 0));
      send_word(to_req(32'hF010_10F0, 0, 0, 2047, 16));
      send_word(to_req(32'h4060_8020, 0, 0, 16, 2047));
      send_word(to_req(32'h4060_8020, 0, 238, 16, 300));
      repeat (7) begin
         lft = $urandom_range(0, 319);
         tp  = $urandom_range(0, 239);
         send_word(to_req($urandom, lft, tp, lft + 16, tp + 16));
      end
      send_block();

      for (int s = 0; s < 6; s++) begin
         wait_drained();
         if (s % 2 == 0) begin
            send_idle_pct  = (s == 0) ? 30 : (s == 2) ? 82 : 0;
            recv_stall_pct = (s == 0) ? 82 : (s == 2) ? 30 : 0;
         end
         cur_width  = (width_plan[s] == 0) ? $urandom_range(1, 1024) : width_plan[s];
         cur_height = (height_plan[s] == 0) ? $urandom_range(1, 1024) : height_plan[s];
         write_reg(CSR_FRAME_WIDTH, cur_width);
         write_reg(CSR_FRAME_HEIGHT, cur_height);
         for (int b = 0; b < block_plan[s]; b++) begin
            send_block();
         end
      end

      wait_drained();
      if (mismatch_count == 0) begin
         $display("yuv_macroblock_to_rgb5551_tb: PASS");
      end else begin
         $display("yuv_macroblock_to_rgb5551_tb: FAIL");
      end
      $finish;
   end

endmodule

// ===== yuv_macroblock_to_rgb5551.f =====
rtl/core/yuvmb_pkg.sv
rtl/core/yuvmb_csr.sv
rtl/core/yuvmb_pos.sv
rtl/core/yuvmb_pixel.sv
rtl/core/yuv_macroblock_to_rgb5551.sv
rtl/core/yuvmb_checker.sv
sim/yuv_macroblock_to_rgb5551_pixel_check.sv
sim/yuv_macroblock_to_rgb5551_tb.sv
